// ===== design/tftb_pkg.sv =====
package tftb_pkg;

  // Pipeline stage numbers; each names the register bank loaded in that stage.
  localparam int STG_PROD  = 0;   // basis matrix products
  localparam int STG_FWD   = 1;   // dual coordinates
  localparam int STG_QUOT  = 2;   // coordinate times reciprocal spacing
  localparam int STG_IDX   = 3;   // rounded grid index
  localparam int STG_GRID  = 4;   // rebuilt grid value, son indices
  localparam int STG_RES   = 5;   // saturated residual
  localparam int STG_SQR   = 6;   // residual squared, residual times sqrt(3)
  localparam int STG_NUM   = 7;   // side numerators in Q.32
  localparam int STG_TRUNC = 8;   // numerator rounded and divided by 2^17
  localparam int STG_RCP   = 9;   // times reciprocal of three
  localparam int STG_SIDE  = 10;  // side probabilities in Q.16
  localparam int STG_OUT   = 11;  // output register
  localparam int NUM_STG   = 12;

  // Largest son index magnitude on either axis, whatever the limit register holds.
  localparam int SON_IDX_CAP = 255;

  // sqrt(3) in Q.30.
  localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;
  // Half of 6 * 2^16, added before the division by six.
  localparam logic [17:0] DIV6_HALF = 18'd196608;
  // floor(t / 3) == (t * RECIP3) >> 33 for any t below 2^32.
  localparam logic [31:0] RECIP3    = 32'hAAAAAAAB;

  typedef logic [NUM_STG-1:0] stage_en_t;

  typedef struct packed {
    logic [8:0] down;
    logic [8:0] mid;
    logic [8:0] up;
  } sons_t;

  typedef enum logic [2:0] {
    REG_BASIS_00  = 3'd0,
    REG_BASIS_01  = 3'd1,
    REG_BASIS_10  = 3'd2,
    REG_BASIS_11  = 3'd3,
    REG_STEP      = 3'd4,
    REG_STEP_RCP  = 3'd5,
    REG_LIMIT_0   = 3'd6,
    REG_LIMIT_1   = 3'd7
  } cfg_idx_t;

endpackage

// ===== design/tftb_axis.sv =====
module tftb_axis (
  input  logic                 clk,
  input  tftb_pkg::stage_en_t  en,
  input  logic signed [31:0]   fwd,
  input  logic [30:0]          step,
  input  logic [30:0]          recip,
  input  logic [7:0]           limit,
  output tftb_pkg::sons_t      sons,
  output logic signed [21:0]   resid
);
  import tftb_pkg::*;

  logic signed [63:0] q_r;
  logic signed [31:0] f2_r, f3_r, f4_r;
  logic signed [31:0] idx_r;
  logic signed [63:0] g_r;
  sons_t              sons4_r, sons5_r;
  logic signed [21:0] resid_r;

  logic signed [63:0] q_adj;
  logic signed [31:0] lim_s, mid_s, down_s, up_s;
  logic signed [63:0] f_ext, diff;
  sons_t              sons_nxt;
  logic signed [21:0] resid_nxt;

  // Round half away from zero: a negative value rounds toward minus infinity
  // after adding one less than half, so one add serves both signs.
  always_comb begin
    q_adj = q_r + (q_r[63] ? 64'sd2147483647 : 64'sd2147483648);
  end

  always_comb begin
    lim_s  = (32'(limit) > SON_IDX_CAP) ? 32'(SON_IDX_CAP) : 32'(limit);
    mid_s  = (idx_r > lim_s) ? lim_s : ((idx_r < -lim_s) ? -lim_s : idx_r);
    down_s = (mid_s > -lim_s) ? mid_s - 32'sd1 : -lim_s;
    up_s   = (mid_s < lim_s) ? mid_s + 32'sd1 : lim_s;
    sons_nxt.down = down_s[8:0];
    sons_nxt.mid  = mid_s[8:0];
    sons_nxt.up   = up_s[8:0];
  end

  always_comb begin
    f_ext = 64'(f4_r);
    diff  = f_ext - g_r;
    if (diff > 64'sd1048576) begin
      resid_nxt = 22'sd1048576;
    end else if (diff < -64'sd1048576) begin
      resid_nxt = -22'sd1048576;
    end else begin
      resid_nxt = diff[21:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_QUOT]) begin
      q_r  <= fwd * $signed({1'b0, recip});
      f2_r <= fwd;
    end
    if (en[STG_IDX]) begin
      idx_r <= q_adj[63:32];
      f3_r  <= f2_r;
    end
    if (en[STG_GRID]) begin
      g_r     <= idx_r * $signed({1'b0, step});
      f4_r    <= f3_r;
      sons4_r <= sons_nxt;
    end
    if (en[STG_RES]) begin
      resid_r <= resid_nxt;
      sons5_r <= sons4_r;
    end
  end

  assign sons  = sons5_r;
  assign resid = resid_r;

endmodule

// ===== design/tftb_side.sv =====
module tftb_side (
  input  logic                 clk,
  input  tftb_pkg::stage_en_t  en,
  input  logic signed [21:0]   resid,
  output logic [23:0]          side_p,
  output logic [23:0]          side_m
);
  import tftb_pkg::*;

  logic [40:0]        xx_r;
  logic signed [53:0] xs_r;
  logic [40:0]        np_r, nm_r;
  logic [24:0]        tp_r, tm_r;
  logic [56:0]        mp_r, mm_r;
  logic [23:0]        side_p_r, side_m_r;

  logic signed [43:0] sq_w;
  logic signed [55:0] base_w, hx_w, np_w, nm_w;
  logic [41:0]        tp_w, tm_w;

  always_comb begin
    sq_w = resid * resid;
  end

  // Both numerators stay above a quarter in Q.32 for any residual, so they
  // are handled as unsigned from here on.
  always_comb begin
    hx_w   = 56'(xs_r) >>> 14;
    base_w = $signed({15'd0, xx_r}) + 56'sh1_0000_0000;
    np_w   = base_w + hx_w;
    nm_w   = base_w - hx_w;
  end

  always_comb begin
    tp_w = {1'b0, np_r} + 42'(DIV6_HALF);
    tm_w = {1'b0, nm_r} + 42'(DIV6_HALF);
  end

  always_ff @(posedge clk) begin
    if (en[STG_SQR]) begin
      xx_r <= sq_w[40:0];
      xs_r <= resid * $signed({1'b0, SQRT3_Q30});
    end
    if (en[STG_NUM]) begin
      np_r <= np_w[40:0];
      nm_r <= nm_w[40:0];
    end
    if (en[STG_TRUNC]) begin
      tp_r <= tp_w[41:17];
      tm_r <= tm_w[41:17];
    end
    if (en[STG_RCP]) begin
      mp_r <= tp_r * RECIP3;
      mm_r <= tm_r * RECIP3;
    end
    if (en[STG_SIDE]) begin
      side_p_r <= mp_r[56:33];
      side_m_r <= mm_r[56:33];
    end
  end

  assign side_p = side_p_r;
  assign side_m = side_m_r;

endmodule

// ===== design/two_factor_tree_node_branching_top.sv =====
// Branching of one node of a two-factor pentanomial tree.
// Input channel (in_*): one transfer carries a node's two state variables in
// Q8.24. Result channel (out_*): one transfer carries the six clamped son
// indices and the five branch probabilities (center, right, top, left,
// bottom) in signed Q.16.
// Configuration port (cfg_*): a write with cfg_we high loads register
// cfg_idx: the four basis entries, the grid spacing and its reciprocal, and
// the two axis limits. The user writes only while no node is in flight;
// the block itself does not enforce this. There are twelve register stages,
// through which runs the chain of multipliers (basis, reciprocal, grid
// value, residual square, divide by three). Throughput is one node per
// cycle while the receiver keeps out_tready high.
// Each stage holds its own valid bit, and a stage loads whenever it or any
// stage after it is empty, so a stalled receiver freezes only the full tail
// of the pipeline and bubbles ahead of it close up. in_tready drops only
// when all twelve stages hold a node.
// Reset (rst_n low at a clock edge) empties the pipeline and restores the
// configuration registers to identity basis, spacing 1.732 and limit 255.
module two_factor_tree_node_branching_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [63:0]   in_tdata,    // state_a[31:0], state_b[63:32]
  output logic          out_tvalid,
  input  logic          out_tready,
  // a_down[8:0], a_mid[17:9], a_up[26:18], b_down[35:27], b_mid[44:36],
  // b_up[53:45], prob_center[71:54], prob_right[89:72], prob_top[107:90],
  // prob_left[125:108], prob_bottom[143:126]
  output logic [143:0]  out_tdata,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_idx,
  input  logic [31:0]   cfg_data
);
  import tftb_pkg::*;

  // Configuration registers.
  logic signed [31:0] basis_r [4];
  logic [30:0]        step_r;
  logic [30:0]        recip_r;
  logic [7:0]         lim0_r, lim1_r;

  // Pipeline control.
  logic [NUM_STG-1:0] vld_r;
  stage_en_t          en;

  // Datapath.
  logic signed [31:0] st_a, st_b;
  logic signed [63:0] prod_r [4];
  logic signed [31:0] fwd0_r, fwd1_r;
  logic signed [31:0] fwd0_nxt, fwd1_nxt;
  sons_t              sa_res, sb_res;
  logic signed [21:0] x_res, y_res;
  sons_t              sa_pipe_r [STG_SQR:STG_OUT];
  sons_t              sb_pipe_r [STG_SQR:STG_OUT];
  logic [23:0]        side_r, side_l, side_t, side_b;
  logic [25:0]        side_sum;
  logic signed [27:0] center_w;
  logic [17:0]        pc_nxt, pr_nxt, pt_nxt, pl_nxt, pb_nxt;
  logic [17:0]        pc_r, pr_r, pt_r, pl_r, pb_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basis_r[0] <= 32'sd65536;
      basis_r[1] <= 32'sd0;
      basis_r[2] <= 32'sd0;
      basis_r[3] <= 32'sd65536;
      step_r     <= 31'd113512;
      recip_r    <= 31'd37837;
      lim0_r     <= 8'd255;
      lim1_r     <= 8'd255;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        REG_BASIS_00: basis_r[0] <= cfg_data;
        REG_BASIS_01: basis_r[1] <= cfg_data;
        REG_BASIS_10: basis_r[2] <= cfg_data;
        REG_BASIS_11: basis_r[3] <= cfg_data;
        REG_STEP:     step_r     <= cfg_data[30:0];
        REG_STEP_RCP: recip_r    <= cfg_data[30:0];
        REG_LIMIT_0:  lim0_r     <= cfg_data[7:0];
        REG_LIMIT_1:  lim1_r     <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // A stage may load when the receiver takes the result or when any stage
  // from it to the output is empty.
  for (genvar g = 0; g < NUM_STG; g++) begin : g_ctrl
    assign en[g] = out_tready | ~(&vld_r[NUM_STG-1:g]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en[g]) begin
        vld_r[g] <= (g == 0) ? in_tvalid : vld_r[(g == 0) ? 0 : g - 1];
      end
    end
  end

  assign in_tready  = en[STG_PROD];
  assign out_tvalid = vld_r[STG_OUT];

  // Basis products, Q.40.
  assign st_a = in_tdata[31:0];
  assign st_b = in_tdata[63:32];

  always_ff @(posedge clk) begin
    if (en[STG_PROD]) begin
      prod_r[0] <= basis_r[0] * st_a;
      prod_r[1] <= basis_r[1] * st_b;
      prod_r[2] <= basis_r[2] * st_a;
      prod_r[3] <= basis_r[3] * st_b;
    end
  end

  // The exact sum is floored to Q16.16 and saturated to 32 bits.
  function automatic logic signed [31:0] fwd_sat(input logic signed [63:0] p,
                                                 input logic signed [63:0] q);
    logic signed [64:0] s;
    logic signed [40:0] f;
    begin
      s = {p[63], p} + {q[63], q};
      f = s[64:24];
      if (f[40:31] == {10{f[40]}}) begin
        fwd_sat = f[31:0];
      end else begin
        fwd_sat = f[40] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
    end
  endfunction

  assign fwd0_nxt = fwd_sat(prod_r[0], prod_r[1]);
  assign fwd1_nxt = fwd_sat(prod_r[2], prod_r[3]);

  always_ff @(posedge clk) begin
    if (en[STG_FWD]) begin
      fwd0_r <= fwd0_nxt;
      fwd1_r <= fwd1_nxt;
    end
  end

  // Per-axis grid index, son indices and residual.
  tftb_axis u_axis0 (
    .clk   (clk),
    .en    (en),
    .fwd   (fwd0_r),
    .step  (step_r),
    .recip (recip_r),
    .limit (lim0_r),
    .sons  (sa_res),
    .resid (x_res)
  );

  tftb_axis u_axis1 (
    .clk   (clk),
    .en    (en),
    .fwd   (fwd1_r),
    .step  (step_r),
    .recip (recip_r),
    .limit (lim1_r),
    .sons  (sb_res),
    .resid (y_res)
  );

  // Son indices ride along while the probabilities are formed.
  for (genvar g = STG_SQR; g <= STG_OUT; g++) begin : g_sons
    always_ff @(posedge clk) begin
      if (en[g]) begin
        sa_pipe_r[g] <= (g == STG_SQR) ? sa_res : sa_pipe_r[(g == STG_SQR) ? g : g - 1];
        sb_pipe_r[g] <= (g == STG_SQR) ? sb_res : sb_pipe_r[(g == STG_SQR) ? g : g - 1];
      end
    end
  end

  // Side probabilities: the plus side of axis 0 is right, of axis 1 top.
  tftb_side u_side0 (
    .clk    (clk),
    .en     (en),
    .resid  (x_res),
    .side_p (side_r),
    .side_m (side_l)
  );

  tftb_side u_side1 (
    .clk    (clk),
    .en     (en),
    .resid  (y_res),
    .side_p (side_t),
    .side_m (side_b)
  );

  // Center is one minus the unsaturated sides; then all five are clipped
  // to plus or minus one. Sides are never negative.
  function automatic logic [17:0] side_sat(input logic [23:0] s);
    begin
      side_sat = (s > 24'd65536) ? 18'd65536 : s[17:0];
    end
  endfunction

  always_comb begin
    side_sum = 26'(side_r) + 26'(side_l) + 26'(side_t) + 26'(side_b);
    center_w = 28'sd65536 - $signed({2'b00, side_sum});
    if (center_w > 28'sd65536) begin
      pc_nxt = 18'd65536;
    end else if (center_w < -28'sd65536) begin
      pc_nxt = 18'h30000;
    end else begin
      pc_nxt = center_w[17:0];
    end
    pr_nxt = side_sat(side_r);
    pt_nxt = side_sat(side_t);
    pl_nxt = side_sat(side_l);
    pb_nxt = side_sat(side_b);
  end

  always_ff @(posedge clk) begin
    if (en[STG_OUT]) begin
      pc_r <= pc_nxt;
      pr_r <= pr_nxt;
      pt_r <= pt_nxt;
      pl_r <= pl_nxt;
      pb_r <= pb_nxt;
    end
  end

  assign out_tdata = {pb_r, pl_r, pt_r, pr_r, pc_r,
                      sb_pipe_r[STG_OUT].up, sb_pipe_r[STG_OUT].mid,
                      sb_pipe_r[STG_OUT].down,
                      sa_pipe_r[STG_OUT].up, sa_pipe_r[STG_OUT].mid,
                      sa_pipe_r[STG_OUT].down};

  // The input side is open whenever the output register is empty.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low with an empty output register");

  // Son indices come out ordered down, mid, up on both axes.
  a_sons_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(sa_pipe_r[STG_OUT].down) <= $signed(sa_pipe_r[STG_OUT].mid)) &&
      ($signed(sa_pipe_r[STG_OUT].mid)  <= $signed(sa_pipe_r[STG_OUT].up))  &&
      ($signed(sb_pipe_r[STG_OUT].down) <= $signed(sb_pipe_r[STG_OUT].mid)) &&
      ($signed(sb_pipe_r[STG_OUT].mid)  <= $signed(sb_pipe_r[STG_OUT].up)))
    else $error("son indices out of order");

  // The down and up sons are at most two steps apart on both axes.
  a_sons_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(sa_pipe_r[STG_OUT].up) - $signed(sa_pipe_r[STG_OUT].down) <= 2) &&
      ($signed(sb_pipe_r[STG_OUT].up) - $signed(sb_pipe_r[STG_OUT].down) <= 2))
    else $error("son indices spread too far");

  // Side probabilities can never be negative.
  a_sides_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !pr_r[17] && !pt_r[17] && !pl_r[17] && !pb_r[17])
    else $error("negative side probability");

endmodule
